// ----- design/i2cm_pkg.sv -----
// Shared types, codes and defaults for the I2C master transaction engine.
// No dependencies; imported by every module of the block.
`default_nettype none

package i2cm_pkg;

  localparam int unsigned TX_DEPTH_DEF     = 16;
  localparam logic [7:0]  ACK_TIMEOUT_RST  = 8'd5;

  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned IN_USER_W  = 4;
  localparam int unsigned OUT_DATA_W = 16;
  localparam int unsigned OUT_USER_W = 2;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_PUSH  = 2'd1;
  localparam logic [1:0] CMD_BEGIN = 2'd2;

  localparam logic [1:0] KIND_REG_WR = 2'd0;
  localparam logic [1:0] KIND_RAW_WR = 2'd1;
  localparam logic [1:0] KIND_REG_RD = 2'd2;
  localparam logic [1:0] KIND_RAW_RD = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NACK = 2'd1;
  localparam logic [1:0] ST_REJ  = 2'd2;

  typedef enum logic [1:0] {
    OP_NOP   = 2'd0,
    OP_TICK  = 2'd1,
    OP_PUSH  = 2'd2,
    OP_BEGIN = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ROLE_ADDR = 2'd0,
    ROLE_REG  = 2'd1,
    ROLE_DATA = 2'd2
  } role_t;

  typedef enum logic [8:0] {
    PH_IDLE      = 9'b000000001,
    PH_START     = 9'b000000010,
    PH_SEND      = 9'b000000100,
    PH_SEND_TAIL = 9'b000001000,
    PH_ACK       = 9'b000010000,
    PH_NACK_TAIL = 9'b000100000,
    PH_RECV      = 9'b001000000,
    PH_MACK      = 9'b010000000,
    PH_STOP      = 9'b100000000
  } phase_t;

  typedef struct packed {
    op_t        op;
    logic       reject;
    logic [1:0] kind;
    logic [6:0] addr;
    logic [7:0] reg_addr;
    logic [7:0] len;
    logic [7:0] wdata;
    logic       sda;
  } item_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic       rx_last;
    logic       done;
    logic [1:0] status;
  } res_t;

endpackage

`default_nettype wire

// ----- design/i2cm_front.sv -----
// Front end: unpacks input beats, classifies them and queues them two deep.
// Depends on i2cm_pkg.
`default_nettype none

module i2cm_front #(
  parameter int unsigned TX_DEPTH = i2cm_pkg::TX_DEPTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [i2cm_pkg::IN_DATA_W-1:0] in_tdata,
  input  wire logic [i2cm_pkg::IN_USER_W-1:0] in_tuser,
  output logic                                q_valid,
  input  wire logic                           q_ready,
  output i2cm_pkg::item_t                     q_item
);
  import i2cm_pkg::*;

  item_t      dec;
  item_t      slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push, pop;

  always_comb begin
    dec.kind     = in_tuser[3:2];
    dec.addr     = in_tdata[6:0];
    dec.reg_addr = in_tdata[14:7];
    dec.len      = in_tdata[22:15];
    dec.wdata    = in_tdata[30:23];
    dec.sda      = in_tdata[31];
    dec.reject   = (in_tuser[3:2] == KIND_REG_WR || in_tuser[3:2] == KIND_RAW_WR) &&
                   ({1'b0, in_tdata[22:15]} > 9'(TX_DEPTH));
    unique case (in_tuser[1:0])
      CMD_TICK:  dec.op = OP_TICK;
      CMD_PUSH:  dec.op = OP_PUSH;
      CMD_BEGIN: dec.op = OP_BEGIN;
      default:   dec.op = OP_NOP;
    endcase
  end

  assign in_tready = (count_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (count_r != 2'd0);
  assign pop       = q_valid && q_ready;
  assign q_item    = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= dec;
    end
  end

endmodule

`default_nettype wire

// ----- design/i2cm_engine.sv -----
// Back end: bus sequencer, write buffer memory and acknowledge timer.
// Executes one queued item per cycle while the result queue accepts; depends on i2cm_pkg.
`default_nettype none

module i2cm_engine #(
  parameter int unsigned TX_DEPTH = i2cm_pkg::TX_DEPTH_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cfg_wr_en,
  input  wire logic [7:0]      cfg_wr_data,
  input  wire logic            q_valid,
  output logic                 q_ready,
  input  wire i2cm_pkg::item_t q_item,
  output logic                 res_valid,
  input  wire logic            res_ready,
  output i2cm_pkg::res_t       res
);
  import i2cm_pkg::*;

  localparam int unsigned AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
  localparam int unsigned FW = $clog2(TX_DEPTH + 1);

  logic [7:0]    tmo_r;
  logic [7:0]    mem [TX_DEPTH];
  logic [7:0]    rd_q;

  phase_t        phase_r, phase_nxt;
  logic [1:0]    sub_r, sub_nxt;
  logic [3:0]    bitc_r, bitc_nxt;
  logic [7:0]    bytec_r, bytec_nxt;
  logic [7:0]    shreg_r, shreg_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [6:0]    laddr_r, laddr_nxt;
  logic [7:0]    lreg_r, lreg_nxt;
  logic [7:0]    llen_r, llen_nxt;
  logic [1:0]    lkind_r, lkind_nxt;
  logic [7:0]    ackt_r, ackt_nxt;
  logic          scl_r, scl_nxt;
  logic          sda_r, sda_nxt;
  role_t         role_r, role_nxt;
  logic          rdir_r, rdir_nxt;
  logic          nacked_r, nacked_nxt;

  logic          fire;
  logic          mem_we;
  logic [7:0]    ackt_inc;
  logic [3:0]    bitc_inc;
  logic [7:0]    bytec_inc;
  logic [7:0]    rx_shift;
  logic          more_data;
  logic          more_read;
  logic          do_data, do_read, do_reg, do_restart;

  assign fire      = q_valid && res_ready;
  assign q_ready   = res_ready;
  assign res_valid = fire;
  assign ackt_inc  = ackt_r + 8'd1;
  assign bitc_inc  = bitc_r + 4'd1;
  assign bytec_inc = bytec_r + 8'd1;
  assign rx_shift  = {shreg_r[6:0], q_item.sda};
  assign more_data = (bytec_r < llen_r) && ({1'b0, bytec_r} < 9'(TX_DEPTH));
  assign more_read = (bytec_r < llen_r);

  always_comb begin
    do_data    = 1'b0;
    do_read    = 1'b0;
    do_reg     = 1'b0;
    do_restart = 1'b0;
    unique case (role_r)
      ROLE_ADDR: begin
        if (rdir_r) begin
          do_read = 1'b1;
        end else if (lkind_r == KIND_REG_WR || lkind_r == KIND_REG_RD) begin
          do_reg = 1'b1;
        end else begin
          do_data = 1'b1;
        end
      end
      ROLE_REG: begin
        if (lkind_r == KIND_REG_RD) begin
          do_restart = 1'b1;
        end else begin
          do_data = 1'b1;
        end
      end
      default: do_data = 1'b1;
    endcase
  end

  always_comb begin
    phase_nxt  = phase_r;
    sub_nxt    = sub_r;
    bitc_nxt   = bitc_r;
    bytec_nxt  = bytec_r;
    shreg_nxt  = shreg_r;
    fill_nxt   = fill_r;
    laddr_nxt  = laddr_r;
    lreg_nxt   = lreg_r;
    llen_nxt   = llen_r;
    lkind_nxt  = lkind_r;
    ackt_nxt   = ackt_r;
    scl_nxt    = scl_r;
    sda_nxt    = sda_r;
    role_nxt   = role_r;
    rdir_nxt   = rdir_r;
    nacked_nxt = nacked_r;
    mem_we     = 1'b0;
    res        = '0;

    if (fire) begin
      unique case (q_item.op)
        OP_PUSH: begin
          if (phase_r == PH_IDLE && fill_r < FW'(TX_DEPTH)) begin
            mem_we   = 1'b1;
            fill_nxt = fill_r + FW'(1);
          end
        end
        OP_BEGIN: begin
          if (phase_r == PH_IDLE) begin
            if (q_item.reject) begin
              res.done   = 1'b1;
              res.status = ST_REJ;
              fill_nxt   = '0;
              sub_nxt    = 2'd0;
              bitc_nxt   = 4'd0;
            end else begin
              lkind_nxt  = q_item.kind;
              laddr_nxt  = q_item.addr;
              lreg_nxt   = q_item.reg_addr;
              llen_nxt   = q_item.len;
              bytec_nxt  = 8'd0;
              bitc_nxt   = 4'd0;
              sub_nxt    = 2'd0;
              ackt_nxt   = 8'd0;
              nacked_nxt = 1'b0;
              rdir_nxt   = (q_item.kind == KIND_RAW_RD);
              phase_nxt  = PH_START;
            end
          end
        end
        OP_TICK: begin
          unique case (phase_r)
            PH_START: begin
              unique case (sub_r)
                2'd0:    sda_nxt = 1'b1;
                2'd1:    scl_nxt = 1'b1;
                2'd2:    sda_nxt = 1'b0;
                default: scl_nxt = 1'b0;
              endcase
              sub_nxt = sub_r + 2'd1;
              if (sub_r == 2'd3) begin
                shreg_nxt = {laddr_r, rdir_r};
                role_nxt  = ROLE_ADDR;
                bitc_nxt  = 4'd0;
                sub_nxt   = 2'd0;
                phase_nxt = PH_SEND;
              end
            end
            PH_SEND: begin
              if (sub_r == 2'd0) begin
                scl_nxt = 1'b0;
              end else if (sub_r == 2'd1) begin
                sda_nxt = shreg_r[3'd7 - bitc_r[2:0]];
              end else begin
                scl_nxt = 1'b1;
              end
              sub_nxt = sub_r + 2'd1;
              if (sub_r == 2'd2) begin
                sub_nxt  = 2'd0;
                bitc_nxt = bitc_inc;
                if (bitc_inc >= 4'd8) begin
                  phase_nxt = PH_SEND_TAIL;
                end
              end
            end
            PH_SEND_TAIL: begin
              scl_nxt   = 1'b0;
              ackt_nxt  = 8'd0;
              phase_nxt = PH_ACK;
            end
            PH_ACK: begin
              sda_nxt = 1'b1;
              if (!q_item.sda) begin
                scl_nxt = 1'b0;
                if (do_reg) begin
                  shreg_nxt = lreg_r;
                  role_nxt  = ROLE_REG;
                  bitc_nxt  = 4'd0;
                  sub_nxt   = 2'd0;
                  phase_nxt = PH_SEND;
                end else if (do_restart) begin
                  rdir_nxt  = 1'b1;
                  sub_nxt   = 2'd0;
                  phase_nxt = PH_START;
                end else if (do_read) begin
                  sub_nxt  = 2'd0;
                  bitc_nxt = 4'd0;
                  if (more_read) begin
                    shreg_nxt = 8'd0;
                    phase_nxt = PH_RECV;
                  end else begin
                    phase_nxt = PH_MACK;
                  end
                end else if (do_data && more_data) begin
                  shreg_nxt = rd_q;
                  bytec_nxt = bytec_inc;
                  role_nxt  = ROLE_DATA;
                  bitc_nxt  = 4'd0;
                  sub_nxt   = 2'd0;
                  phase_nxt = PH_SEND;
                end else begin
                  sub_nxt   = 2'd0;
                  phase_nxt = PH_STOP;
                end
              end else begin
                scl_nxt  = 1'b1;
                ackt_nxt = ackt_inc;
                if (ackt_inc >= tmo_r) begin
                  phase_nxt = PH_NACK_TAIL;
                end
              end
            end
            PH_NACK_TAIL: begin
              scl_nxt    = 1'b0;
              nacked_nxt = 1'b1;
              sub_nxt    = 2'd0;
              phase_nxt  = PH_STOP;
            end
            PH_RECV: begin
              sda_nxt = 1'b1;
              if (sub_r == 2'd0) begin
                scl_nxt = 1'b0;
              end else if (sub_r == 2'd2) begin
                scl_nxt   = 1'b1;
                shreg_nxt = rx_shift;
              end
              sub_nxt = sub_r + 2'd1;
              if (sub_r == 2'd2) begin
                sub_nxt  = 2'd0;
                bitc_nxt = bitc_inc;
                if (bitc_inc >= 4'd8) begin
                  bytec_nxt    = bytec_inc;
                  res.rx_byte  = rx_shift;
                  res.rx_valid = 1'b1;
                  res.rx_last  = (bytec_inc >= llen_r);
                  bitc_nxt     = 4'd0;
                  phase_nxt    = PH_MACK;
                end
              end
            end
            PH_MACK: begin
              if (sub_r == 2'd0) begin
                scl_nxt = 1'b0;
                sda_nxt = (bytec_r >= llen_r);
              end else if (sub_r == 2'd1) begin
                scl_nxt = 1'b1;
              end else begin
                scl_nxt = 1'b0;
              end
              sub_nxt = sub_r + 2'd1;
              if (sub_r == 2'd2) begin
                sub_nxt = 2'd0;
                if (more_read) begin
                  bitc_nxt  = 4'd0;
                  shreg_nxt = 8'd0;
                  phase_nxt = PH_RECV;
                end else begin
                  phase_nxt = PH_STOP;
                end
              end
            end
            PH_STOP: begin
              unique case (sub_r)
                2'd0:    scl_nxt = 1'b0;
                2'd1:    sda_nxt = 1'b0;
                2'd2:    scl_nxt = 1'b1;
                default: sda_nxt = 1'b1;
              endcase
              sub_nxt = sub_r + 2'd1;
              if (sub_r == 2'd3) begin
                res.done   = 1'b1;
                res.status = nacked_r ? ST_NACK : ST_OK;
                phase_nxt  = PH_IDLE;
                fill_nxt   = '0;
                sub_nxt    = 2'd0;
                bitc_nxt   = 4'd0;
              end
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
    end

    res.scl  = scl_nxt;
    res.sda  = sda_nxt;
    res.busy = (phase_nxt != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tmo_r    <= ACK_TIMEOUT_RST;
      phase_r  <= PH_IDLE;
      sub_r    <= 2'd0;
      bitc_r   <= 4'd0;
      bytec_r  <= 8'd0;
      shreg_r  <= 8'd0;
      fill_r   <= '0;
      laddr_r  <= 7'd0;
      lreg_r   <= 8'd0;
      llen_r   <= 8'd0;
      lkind_r  <= 2'd0;
      ackt_r   <= 8'd0;
      scl_r    <= 1'b1;
      sda_r    <= 1'b1;
      role_r   <= ROLE_ADDR;
      rdir_r   <= 1'b0;
      nacked_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        tmo_r <= cfg_wr_data;
      end
      phase_r  <= phase_nxt;
      sub_r    <= sub_nxt;
      bitc_r   <= bitc_nxt;
      bytec_r  <= bytec_nxt;
      shreg_r  <= shreg_nxt;
      fill_r   <= fill_nxt;
      laddr_r  <= laddr_nxt;
      lreg_r   <= lreg_nxt;
      llen_r   <= llen_nxt;
      lkind_r  <= lkind_nxt;
      ackt_r   <= ackt_nxt;
      scl_r    <= scl_nxt;
      sda_r    <= sda_nxt;
      role_r   <= role_nxt;
      rdir_r   <= rdir_nxt;
      nacked_r <= nacked_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[fill_r[AW-1:0]] <= q_item.wdata;
    end
    rd_q <= mem[bytec_nxt[AW-1:0]];
  end

`ifndef NO_ASSERTIONS
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.done |-> !res.busy)
    else $error("request ended while still busy");

  a_rx_excl_done: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> !(res.rx_valid && res.done))
    else $error("received byte and end of request on the same beat");

  a_status_idle: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res.done |-> res.status == ST_OK)
    else $error("status set without end of request");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(TX_DEPTH))
    else $error("write buffer fill beyond depth");

  a_fill_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != PH_IDLE && phase_nxt != PH_IDLE |-> fill_nxt == fill_r)
    else $error("write buffer changed during a transaction");
`endif

endmodule

`default_nettype wire

// ----- design/i2cm_out_buf.sv -----
// Result queue: two-entry buffer between the sequencer and the output channel.
// Packs result beats for the output ports; depends on i2cm_pkg.
`default_nettype none

module i2cm_out_buf (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            res_valid,
  output logic                                 res_ready,
  input  wire i2cm_pkg::res_t                  res,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [i2cm_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic [i2cm_pkg::OUT_USER_W-1:0]      out_tuser,
  output logic                                 out_tlast
);
  import i2cm_pkg::*;

  res_t       slot_r [2];
  res_t       head;
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;
  logic       push, pop;

  assign res_ready  = (count_r != 2'd2);
  assign push       = res_valid && res_ready;
  assign out_tvalid = (count_r != 2'd0);
  assign pop        = out_tvalid && out_tready;
  assign head       = slot_r[rd_ptr_r];

  assign out_tdata = {3'd0, head.status, head.rx_byte, head.busy, head.sda, head.scl};
  assign out_tuser = {head.done, head.rx_valid};
  assign out_tlast = head.rx_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= res;
    end
  end

endmodule

`default_nettype wire

// ----- design/i2c_master_transaction_engine.sv -----
// I2C master transaction engine, top level.
// Instantiates i2cm_front, i2cm_engine and i2cm_out_buf; depends on i2cm_pkg.
//
// Usage: each input beat is one command (in_tuser[1:0]): a bus tick carrying
// the sampled SDA level, a write-buffer push, or a transaction request whose
// kind sits in in_tuser[3:2]. Every accepted input beat yields exactly one
// output beat carrying the SCL/SDA drive levels, busy, any received byte
// (out_tuser[0] valid, out_tlast last) and, on completion, done (out_tuser[1])
// with status.
// Throughput: one beat per clock while neither side stalls; the sequencer retires one
// queued command each cycle while the result queue accepts. Path: input queue
// (registered), sequencer (combinational), result queue (registered).
// Stalls: when out_tready is low the result queue fills, the sequencer holds,
// and the two-deep input queue drops in_tready once it is full.
// Reset (rst_n low, synchronous): bus released (SCL and SDA high), sequencer idle,
// write buffer and both queues empty, acknowledge timeout back to 5. Write the
// acknowledge timeout (cfg_wr_data) only while the engine is idle; not enforced.
`default_nettype none

module i2c_master_transaction_engine #(
  parameter int unsigned TX_DEPTH = i2cm_pkg::TX_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_wr_en,
  input  wire logic [7:0]                      cfg_wr_data,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // device_addr[6:0], reg_addr[14:7], length[22:15], wr_data[30:23], sda_in[31]
  input  wire logic [i2cm_pkg::IN_DATA_W-1:0]  in_tdata,
  // cmd[1:0], kind[3:2]
  input  wire logic [i2cm_pkg::IN_USER_W-1:0]  in_tuser,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // scl_level[0], sda_level[1], busy_res[2], rx_byte[10:3], status[12:11], zero[15:13]
  output logic [i2cm_pkg::OUT_DATA_W-1:0]      out_tdata,
  // rx_valid[0], done_res[1]
  output logic [i2cm_pkg::OUT_USER_W-1:0]      out_tuser,
  // rx_last
  output logic                                 out_tlast
);
  import i2cm_pkg::*;

  logic  q_valid, q_ready;
  item_t q_item;
  logic  res_valid, res_ready;
  res_t  res;

  i2cm_front #(
    .TX_DEPTH (TX_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item)
  );

  i2cm_engine #(
    .TX_DEPTH (TX_DEPTH)
  ) u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_valid     (q_valid),
    .q_ready     (q_ready),
    .q_item      (q_item),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  i2cm_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire
